>>> rtl/brb_pkg.sv
// Package for the byte ring buffer with burst drain.
// Holds buffer geometry, opcode, result kind, pointer unit and sequencer types.
// No dependencies.
package brb_pkg;

  localparam int PTR_W     = 12;
  localparam int BUF_DEPTH = 1 << PTR_W;
  localparam int FIELD_W   = 12;
  localparam int LIMIT_W   = 6;
  localparam int BURST_MAX = 32;
  localparam int FIELD_MAX = (1 << FIELD_W) - 1;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_GET     = 3'd1,
    OP_DRAIN   = 3'd2,
    OP_SET_PTR = 3'd3,
    OP_CLEAR   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_PAUSE = 2'd2,
    KIND_DROP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ALU_INC,
    ALU_SUB,
    ALU_SUBM1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUT,
    S_DRLEN,
    S_RDREQ,
    S_RDWAIT,
    S_FILL,
    S_FREE,
    S_EMIT
  } state_t;

  function automatic logic [FIELD_W-1:0] sat_field(input logic [PTR_W-1:0] v);
    logic [PTR_W:0] wide;
    wide = {1'b0, v};
    if (wide > (PTR_W+1)'(FIELD_MAX)) begin
      return FIELD_W'(FIELD_MAX);
    end
    return FIELD_W'(v);
  endfunction

endpackage

>>> rtl/byte_ring_buffer_burst_drain.sv
// Top level of the byte ring buffer with burst drain: sequencer and pointer state.
// Depends on brb_pkg, brb_ram, brb_ptr_alu.
//
//   channel  | handshake                  | payload
//   item     | item_valid / item_stall    | opcode, data_byte, chunk_end, new_pointer
//   result   | result_valid / result_stall| kind, out_byte, last, fill_level, free_space
//   config   | cfg_write_en               | cfg_write_data (burst_limit)
//
// One item is taken at a time; item_stall is high until its last result is loaded.
// Set pointer, clear, empty get and unused opcodes pass decode, fill, free and emit to
// the result register; put adds the put state, empty drain the drain length state, and
// get a read request and wait (RAM read, then two distances on the single pointer
// unit). After the drain length state, a drain repeats read request, read wait, fill,
// free and emit per byte. Synchronous reset clears pointers and sets burst_limit to 32;
// the store is not cleared. A stalled result holds the sequencer before the next load.
module byte_ring_buffer_burst_drain import brb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         opcode,
  input  logic [7:0]         data_byte,
  input  logic               chunk_end,
  input  logic [11:0]        new_pointer,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic [7:0]         out_byte,
  output logic               last,
  output logic [FIELD_W-1:0] fill_level,
  output logic [FIELD_W-1:0] free_space,
  input  logic               cfg_write_en,
  input  logic [LIMIT_W-1:0] cfg_write_data
);

  state_t             state, state_next;
  logic [PTR_W-1:0]   committed_head, pending_head, read_tail;
  logic [LIMIT_W-1:0] burst_limit, limit_eff, cnt;
  logic [2:0]         op_r;
  logic [7:0]         data_r;
  logic               cend_r;
  logic [11:0]        np_r;
  kind_t              res_kind;
  logic [7:0]         res_byte;
  logic               res_last;
  logic [FIELD_W-1:0] fill_r;
  logic [PTR_W-1:0]   alu_q, alu_res, alu_a, alu_b;
  alu_op_t            alu_op;
  logic               accept, out_free, put_full;
  logic               ram_we, ram_re;
  logic [7:0]         ram_rdata;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign put_full = (alu_q == read_tail);
  assign ram_we   = (state == S_PUT) && !put_full;
  assign ram_re   = (state == S_RDREQ);

  always_comb begin
    if (burst_limit == '0) begin
      limit_eff = LIMIT_W'(1);
    end else if (burst_limit > LIMIT_W'(BURST_MAX)) begin
      limit_eff = LIMIT_W'(BURST_MAX);
    end else begin
      limit_eff = burst_limit;
    end
  end

  brb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pending_head),
    .wr_data (data_r),
    .rd_en   (ram_re),
    .rd_addr (read_tail),
    .rd_data (ram_rdata)
  );

  brb_ptr_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    alu_op     = ALU_SUB;
    alu_a      = committed_head;
    alu_b      = read_tail;
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_r)
          OP_PUT: begin
            alu_op     = ALU_INC;
            alu_a      = pending_head;
            state_next = S_PUT;
          end
          OP_GET:   state_next = (committed_head != read_tail) ? S_RDREQ : S_FILL;
          OP_DRAIN: state_next = S_DRLEN;
          default:  state_next = S_FILL;
        endcase
      end
      S_PUT:    state_next = S_FILL;
      S_DRLEN:  state_next = (alu_q == '0) ? S_FILL : S_RDREQ;
      S_RDREQ: begin
        alu_op     = ALU_INC;
        alu_a      = read_tail;
        state_next = S_RDWAIT;
      end
      S_RDWAIT: state_next = S_FILL;
      S_FILL:   state_next = S_FREE;
      S_FREE: begin
        alu_op     = ALU_SUBM1;
        alu_a      = read_tail;
        alu_b      = pending_head;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        alu_op = ALU_SUBM1;
        alu_a  = read_tail;
        alu_b  = pending_head;
        if (out_free) begin
          state_next = res_last ? S_IDLE : S_RDREQ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_head <= '0;
      pending_head   <= '0;
      read_tail      <= '0;
      burst_limit    <= LIMIT_W'(BURST_MAX);
      result_valid   <= 1'b0;
    end else begin
      alu_q <= alu_res;
      if (cfg_write_en) begin
        burst_limit <= cfg_write_data;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r   <= opcode;
            data_r <= data_byte;
            cend_r <= chunk_end;
            np_r   <= new_pointer;
          end
        end
        S_DECODE: begin
          res_kind <= KIND_ACK;
          res_byte <= '0;
          res_last <= 1'b1;
          cnt      <= LIMIT_W'(1);
          case (op_r)
            OP_SET_PTR: begin
              committed_head <= PTR_W'(np_r);
              pending_head   <= PTR_W'(np_r);
            end
            OP_CLEAR: begin
              committed_head <= '0;
              pending_head   <= '0;
              read_tail      <= '0;
            end
            default: ;
          endcase
        end
        S_PUT: begin
          if (!put_full) begin
            pending_head <= alu_q;
          end
          if (cend_r) begin
            committed_head <= put_full ? pending_head : alu_q;
          end
          res_kind <= put_full ? KIND_DROP : KIND_ACK;
        end
        S_DRLEN: begin
          if (alu_q == '0) begin
            res_kind <= KIND_PAUSE;
          end else if (alu_q < PTR_W'(limit_eff)) begin
            cnt <= LIMIT_W'(alu_q);
          end else begin
            cnt <= limit_eff;
          end
        end
        S_RDREQ: read_tail <= alu_res;
        S_RDWAIT: begin
          res_kind <= KIND_BYTE;
          res_byte <= ram_rdata;
          res_last <= (cnt == LIMIT_W'(1));
          cnt      <= cnt - LIMIT_W'(1);
        end
        S_FREE: fill_r <= sat_field(alu_q);
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            kind         <= res_kind;
            out_byte     <= res_byte;
            last         <= res_last;
            fill_level   <= fill_r;
            free_space   <= sat_field(alu_q);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/brb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/brb_ptr_alu.sv
// Shared pointer arithmetic unit: ring increment, ring distance, distance minus one.
// Depends on brb_pkg.
module brb_ptr_alu import brb_pkg::*; (
  input  alu_op_t          op,
  input  logic [PTR_W-1:0] a,
  input  logic [PTR_W-1:0] b,
  output logic [PTR_W-1:0] res
);

  logic [PTR_W-1:0] b_op;
  logic             cin;

  always_comb begin
    b_op = ~b;
    cin  = 1'b1;
    case (op)
      ALU_INC: begin
        b_op = '0;
        cin  = 1'b1;
      end
      ALU_SUB: begin
        b_op = ~b;
        cin  = 1'b1;
      end
      ALU_SUBM1: begin
        b_op = ~b;
        cin  = 1'b0;
      end
      default: begin
        b_op = ~b;
        cin  = 1'b1;
      end
    endcase
  end

  assign res = a + b_op + PTR_W'(cin);

endmodule

>>> bench/brb_checker.sv
// Checker for the byte ring buffer with burst drain: watches the item, result and
// register ports, predicts every result of each item transfer and compares them in order.
// Depends on brb_pkg.
module brb_checker import brb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [2:0]         opcode,
  input  logic [7:0]         data_byte,
  input  logic               chunk_end,
  input  logic [PTR_W-1:0]   new_pointer,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         out_byte,
  input  logic               last,
  input  logic [FIELD_W-1:0] fill_level,
  input  logic [FIELD_W-1:0] free_space,
  input  logic               cfg_write_en,
  input  logic [LIMIT_W-1:0] cfg_write_data,
  output int                 fail_count,
  output int                 pending_results,
  output logic [PTR_W-1:0]   tail_ptr,
  output int                 clean_run
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 40;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic               last;
    logic [FIELD_W-1:0] fill;
    logic [FIELD_W-1:0] room;
  } ring_result_t;

  logic [7:0]         ring_mem [BUF_DEPTH];
  bit                 written [BUF_DEPTH];
  logic [PTR_W-1:0]   commit_head;
  logic [PTR_W-1:0]   write_head;
  logic [PTR_W-1:0]   tail;
  logic [LIMIT_W-1:0] drain_limit;
  ring_result_t       expected_q [$];
  int                 mismatches;

  function automatic ring_result_t status_result(kind_t k, logic [7:0] d, logic l);
    ring_result_t     r;
    logic [PTR_W-1:0] fill;
    logic [PTR_W-1:0] used;
    logic [PTR_W-1:0] room;
    fill = commit_head - tail;
    used = write_head - tail;
    room = PTR_W'(BUF_DEPTH - 1) - used;
    r.kind = k;
    r.data = d;
    r.last = l;
    r.fill = fill;
    r.room = room;
    return r;
  endfunction

  task automatic take_item(logic [2:0] op, logic [7:0] d, logic cend, logic [PTR_W-1:0] np);
    logic [PTR_W-1:0]   nxt;
    logic [PTR_W-1:0]   avail;
    logic [LIMIT_W-1:0] lim;
    logic               full;
    logic [7:0]         rd;
    case (op)
      OP_PUT: begin
        nxt = write_head + 1'b1;
        full = (nxt == tail);
        if (!full) begin
          ring_mem[write_head] = d;
          written[write_head] = 1'b1;
          write_head = nxt;
        end
        if (cend) begin
          commit_head = write_head;
        end
        expected_q.push_back(status_result(full ? KIND_DROP : KIND_ACK, 8'd0, 1'b1));
      end
      OP_GET: begin
        if (commit_head != tail) begin
          rd = ring_mem[tail];
          tail = tail + 1'b1;
          expected_q.push_back(status_result(KIND_BYTE, rd, 1'b1));
        end else begin
          expected_q.push_back(status_result(KIND_ACK, 8'd0, 1'b1));
        end
      end
      OP_DRAIN: begin
        avail = commit_head - tail;
        lim = drain_limit;
        if (lim == 0) begin
          lim = LIMIT_W'(1);
        end
        if (lim > BURST_MAX) begin
          lim = LIMIT_W'(BURST_MAX);
        end
        if (avail == 0) begin
          expected_q.push_back(status_result(KIND_PAUSE, 8'd0, 1'b1));
        end else begin
          if (avail > lim) begin
            avail = PTR_W'(lim);
          end
          for (int i = 1; i <= avail; i++) begin
            rd = ring_mem[tail];
            tail = tail + 1'b1;
            expected_q.push_back(status_result(KIND_BYTE, rd, i == avail));
          end
        end
      end
      OP_SET_PTR: begin
        commit_head = np;
        write_head = np;
        expected_q.push_back(status_result(KIND_ACK, 8'd0, 1'b1));
      end
      OP_CLEAR: begin
        commit_head = '0;
        write_head = '0;
        tail = '0;
        expected_q.push_back(status_result(KIND_ACK, 8'd0, 1'b1));
      end
      default: begin
        expected_q.push_back(status_result(KIND_ACK, 8'd0, 1'b1));
      end
    endcase
  endtask

  // count written entries from the tail onward
  function automatic int written_run();
    int               n;
    logic [PTR_W-1:0] p;
    n = 0;
    p = tail;
    while (n < BUF_DEPTH - 1 && written[p]) begin
      n++;
      p = p + 1'b1;
    end
    return n;
  endfunction

  function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                      logic [FIELD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    if (rst) begin
      commit_head = '0;
      write_head = '0;
      tail = '0;
      drain_limit = LIMIT_W'(BURST_MAX);
      expected_q.delete();
    end else begin
      if (cfg_write_en) begin
        drain_limit = cfg_write_data;
      end
      if (item_valid && !item_stall) begin
        take_item(opcode, data_byte, chunk_end, new_pointer);
      end
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP) begin
            $error("result transfer with nothing expected: kind %0d, byte %0d", kind, out_byte);
          end
        end else begin
          want = expected_q.pop_front();
          check_field("kind", FIELD_W'(want.kind), FIELD_W'(kind));
          check_field("out_byte", FIELD_W'(want.data), FIELD_W'(out_byte));
          check_field("last", FIELD_W'(want.last), FIELD_W'(last));
          check_field("fill_level", want.fill, fill_level);
          check_field("free_space", want.room, free_space);
        end
      end
    end
    fail_count <= mismatches;
    pending_results <= expected_q.size();
    tail_ptr <= tail;
    if (rst || (item_valid && !item_stall)) begin
      clean_run <= written_run();
    end
  end

endmodule

>>> bench/tb_top.sv
// Top of the byte ring buffer bench: clock, reset, item and register stimulus,
// random output stalls, watchdog and verdict. Depends on brb_pkg, brb_checker and
// byte_ring_buffer_burst_drain.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import brb_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 24;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [2:0]         opcode = '0;
  logic [7:0]         data_byte = '0;
  logic               chunk_end = 1'b0;
  logic [PTR_W-1:0]   new_pointer = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         kind;
  logic [7:0]         out_byte;
  logic               last;
  logic [FIELD_W-1:0] fill_level;
  logic [FIELD_W-1:0] free_space;
  logic               cfg_write_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_write_data = '0;

  int                 fail_count;
  int                 pending_results;
  logic [PTR_W-1:0]   tail_ptr;
  int                 clean_run;

  bit                 sender_gaps = 1'b0;
  bit                 receiver_gaps = 1'b0;
  bit                 long_hold_req = 1'b0;
  bit                 long_hold_done = 1'b0;
  int                 quiet_cycles = 0;
  int                 items_moved = 0;
  int                 results_moved = 0;
  logic [LIMIT_W-1:0] mid_limit;

  byte_ring_buffer_burst_drain DUT (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .chunk_end      (chunk_end),
    .new_pointer    (new_pointer),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .out_byte       (out_byte),
    .last           (last),
    .fill_level     (fill_level),
    .free_space     (free_space),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  brb_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .opcode          (opcode),
    .data_byte       (data_byte),
    .chunk_end       (chunk_end),
    .new_pointer     (new_pointer),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .out_byte        (out_byte),
    .last            (last),
    .fill_level      (fill_level),
    .free_space      (free_space),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .tail_ptr        (tail_ptr),
    .clean_run       (clean_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      items_moved <= items_moved + 1;
    end
    if (!rst && result_valid && !result_stall) begin
      results_moved <= results_moved + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
        long_hold_done <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [7:0] d, logic cend, logic [PTR_W-1:0] np);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    opcode <= op;
    data_byte <= d;
    chunk_end <= cend;
    new_pointer <= np;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] v);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_directed();
    send_item(OP_GET, 8'h00, 1'b0, 12'h000);
    send_item(OP_DRAIN, 8'hFF, 1'b1, 12'hFFF);
    send_item(OP_PUT, 8'h00, 1'b0, 12'hFFF);
    send_item(OP_PUT, 8'hFF, 1'b0, 12'h000);
    send_item(OP_GET, 8'h00, 1'b0, 12'h000);
    send_item(OP_PUT, 8'hA5, 1'b1, 12'h000);
    send_item(OP_GET, 8'h00, 1'b0, 12'h000);
    send_item(OP_DRAIN, 8'h00, 1'b0, 12'h000);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
      send_item(3'(c), 8'hFF, 1'b1, 12'hFFF);
    end
    send_item(OP_CLEAR, 8'h00, 1'b0, 12'h000);
    send_item(OP_SET_PTR, 8'h00, 1'b0, 12'hFFF);
    send_item(OP_PUT, 8'h5A, 1'b0, 12'h000);
    send_item(OP_PUT, 8'hC3, 1'b1, 12'h000);
    send_item(OP_CLEAR, 8'hFF, 1'b1, 12'hFFF);
    send_item(OP_SET_PTR, 8'h00, 1'b0, 12'h002);
    send_item(OP_DRAIN, 8'h00, 1'b0, 12'h000);
  endtask

  task automatic random_phase(int n_items);
    int               sent;
    int               len;
    int               pick;
    logic [PTR_W-1:0] np;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_item(OP_PUT, 8'($urandom),
                    (k == len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0),
                    12'($urandom));
        end
        sent += len;
      end else if (pick < 58) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_item(OP_GET, 8'($urandom), 1'($urandom), 12'($urandom));
        end
        sent += len;
      end else if (pick < 76) begin
        send_item(OP_DRAIN, 8'($urandom), 1'($urandom), 12'($urandom));
        sent++;
      end else if (pick < 84) begin
        wait_idle();
        np = tail_ptr + PTR_W'($urandom_range(0, clean_run));
        send_item(OP_SET_PTR, 8'($urandom), 1'($urandom), np);
        sent++;
      end else if (pick < 90) begin
        // pointer that may lie outside the written span: no reads until the clear
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
          np = 12'($urandom);
        end else begin
          np = tail_ptr - PTR_W'($urandom_range(1, 3));
        end
        send_item(OP_SET_PTR, 8'($urandom), 1'($urandom), np);
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_item(OP_PUT, 8'($urandom), 1'($urandom), 12'($urandom));
        end
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom), 12'($urandom));
        sent += len + 2;
      end else if (pick < 95) begin
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom), 12'($urandom));
        sent++;
      end else begin
        send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 8'($urandom),
                  1'($urandom), 12'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_limit(LIMIT_W'(BURST_MAX));
    sender_gaps = 1'b1;
    receiver_gaps <= 1'b1;
    run_directed();

    set_limit(LIMIT_W'(6'h3F));
    random_phase(PHASE_ITEMS);

    set_limit(LIMIT_W'(1));
    long_hold_req <= 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_item(OP_PUT, 8'($urandom), k == 7, 12'($urandom));
    end
    random_phase(PHASE_ITEMS);

    set_limit(LIMIT_W'(0));
    random_phase(PHASE_ITEMS);

    mid_limit = LIMIT_W'($urandom_range(2, BURST_MAX - 1));
    set_limit(mid_limit);
    random_phase(PHASE_ITEMS);

    sender_gaps = 1'b0;
    receiver_gaps <= 1'b0;
    set_limit(LIMIT_W'(BURST_MAX));
    random_phase(PHASE_ITEMS);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d item transfers and %0d result transfers, burst limits 32, 63,",
             items_moved, results_moved);
    $display("1, 0 and %0d, full-ring drops, pointer moves, clears and a long output hold.",
             mid_limit);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_ptr_alu.sv
rtl/byte_ring_buffer_burst_drain.sv
bench/brb_checker.sv
bench/tb_top.sv
